// ----- design/capv_pkg.sv -----
// ----------------------------------------------------------------------------
// capv_pkg
// shared constants, register codes and fixed-point helpers of the capsule
// vertex generator
// ----------------------------------------------------------------------------
package capv_pkg;

  localparam int DEF_MAX_STACKS       = 256;
  localparam int DEF_MAX_SLICES       = 256;
  localparam int DEF_SINE_TABLE_DEPTH = 256;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam longint      HALF_PI_Q30  = 64'd1686629713;

  localparam logic [2:0]  LAST_VTX     = 3'd5;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_STACK_COUNT = 3'd2,
    REG_SLICE_COUNT = 3'd3,
    REG_PHI_STEP    = 3'd4,
    REG_THETA_STEP  = 3'd5
  } reg_idx_t;

  // taylor series of sin in q30, result rounded to q14 and clamped
  function automatic logic [14:0] sine_from_x(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [65:0] acc;
    logic [63:0]        v;
    x2   = (x * x) >> 30;
    term = x;
    acc  = '0;
    for (int n = 0; n < 9; n++) begin
      if (n % 2 == 1) acc = acc - $signed({2'b00, term});
      else            acc = acc + $signed({2'b00, term});
      term = (term * x2) >> 30;
      term = term / 64'((2 * n + 2) * (2 * n + 3));
    end
    if (acc < 0) acc = '0;
    v = (acc[63:0] + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    return v[14:0];
  endfunction

  // q14 multiply, ties rounded away from zero
  function automatic logic signed [31:0] mul14(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = a * b;
    if (p < 0) r = (p + 64'sd8191) >>> 14;
    else       r = (p + 64'sd8192) >>> 14;
    return r[31:0];
  endfunction

endpackage

// ----- design/capv_trig.sv -----
// ----------------------------------------------------------------------------
// capv_trig
// quarter-wave sine lookup for an angle in turn units (65536 per turn)
// ----------------------------------------------------------------------------
module capv_trig #(
  parameter int SINE_TABLE_DEPTH = capv_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic [15:0]        angle,
  output logic signed [15:0] sine
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

  logic [14:0] tab [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam longint XK = capv_pkg::HALF_PI_Q30 * k / SINE_TABLE_DEPTH;
    assign tab[k] = capv_pkg::sine_from_x(64'(XK));
  end

  logic [1:0]  quad;
  logic [14:0] frac;
  logic [31:0] scaled;
  logic [31:0] idx_full;
  logic [IW-1:0] idx;
  logic [14:0] mag;

  always_comb begin
    quad = angle[15:14];
    frac = {1'b0, angle[13:0]};
    if (quad[0]) frac = 15'd16384 - frac;
    scaled   = 32'(frac) * 32'(SINE_TABLE_DEPTH) + 32'd8192;
    idx_full = scaled >> 14;
    if (idx_full > 32'(SINE_TABLE_DEPTH)) idx_full = 32'(SINE_TABLE_DEPTH);
    idx  = idx_full[IW-1:0];
    mag  = tab[idx];
    sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ----- design/capsule_vertex_generator_core.sv -----
// ----------------------------------------------------------------------------
// capsule_vertex_generator_core
// uv capsule tessellation: one grid cell in, six triangle vertices out
// ----------------------------------------------------------------------------
// A cell (band, slice) is taken when start is high and busy is low. A cell in
// range yields six vertices on consecutive cycles, each shown for one cycle
// with out_valid; out_last_vertex marks the sixth. The first vertex passes
// through the angle, sine lookup, first and second q14 multiply stages. The
// six-vertex issue sequencer holds busy high for a cell in range until its
// sixth vertex issues, so cells can follow back to back. A cell out of range
// yields nothing and busy stays low. The receiver cannot stall; results must
// be taken as they appear. The user must write configuration through the apb
// port only while idle; the core does not enforce it.
module capsule_vertex_generator_core #(
  parameter int MAX_STACKS       = capv_pkg::DEF_MAX_STACKS,
  parameter int MAX_SLICES       = capv_pkg::DEF_MAX_SLICES,
  parameter int SINE_TABLE_DEPTH = capv_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // cell command
  input  logic               start,
  output logic               busy,
  input  logic [8:0]         in_band_index,
  input  logic [7:0]         in_slice_index,
  // vertex results
  output logic               out_valid,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic               out_last_vertex,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------- registers
  logic [15:0] radius_r, half_height_r;
  logic [8:0]  stack_count_r, slice_count_r;
  logic [14:0] phi_step_r, theta_step_r;

  capv_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = capv_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 16'd8192;
      half_height_r <= 16'd8192;
      stack_count_r <= 9'd16;
      slice_count_r <= 9'd16;
      phi_step_r    <= 15'd2048;
      theta_step_r  <= 15'd4096;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        capv_pkg::REG_RADIUS:      radius_r      <= pwdata[15:0];
        capv_pkg::REG_HALF_HEIGHT: half_height_r <= pwdata[15:0];
        capv_pkg::REG_STACK_COUNT: stack_count_r <= pwdata[8:0];
        capv_pkg::REG_SLICE_COUNT: slice_count_r <= pwdata[8:0];
        capv_pkg::REG_PHI_STEP:    phi_step_r    <= pwdata[14:0];
        capv_pkg::REG_THETA_STEP:  theta_step_r  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      capv_pkg::REG_RADIUS:      prdata = {16'd0, radius_r};
      capv_pkg::REG_HALF_HEIGHT: prdata = {16'd0, half_height_r};
      capv_pkg::REG_STACK_COUNT: prdata = {23'd0, stack_count_r};
      capv_pkg::REG_SLICE_COUNT: prdata = {23'd0, slice_count_r};
      capv_pkg::REG_PHI_STEP:    prdata = {17'd0, phi_step_r};
      capv_pkg::REG_THETA_STEP:  prdata = {17'd0, theta_step_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------- cell capture
  // effective counts are clipped to the build limits
  localparam int CW = $clog2(((MAX_STACKS > MAX_SLICES) ? MAX_STACKS : MAX_SLICES) + 1) + 1;
  localparam int WC = (CW > 10) ? CW : 10;

  logic [WC-1:0] stacks_eff, slices_eff;
  logic          cell_ok, accept;

  assign stacks_eff = (WC'(stack_count_r) > WC'(MAX_STACKS)) ? WC'(MAX_STACKS)
                                                              : WC'(stack_count_r);
  assign slices_eff = (WC'(slice_count_r) > WC'(MAX_SLICES)) ? WC'(MAX_SLICES)
                                                              : WC'(slice_count_r);
  assign cell_ok = (WC'(in_band_index) <= stacks_eff) && (WC'(in_slice_index) < slices_eff);

  logic       active_r;
  logic [2:0] cnt_r;
  logic [8:0] band_r;
  logic [7:0] slice_r;
  logic       cyl_r, upper_r;

  // busy drops on the sixth issue so the next cell can follow at once
  assign busy   = active_r && (cnt_r != capv_pkg::LAST_VTX);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= 3'd0;
    end else if (accept) begin
      active_r <= cell_ok;
      cnt_r    <= 3'd0;
    end else if (active_r) begin
      if (cnt_r == capv_pkg::LAST_VTX) begin
        active_r <= 1'b0;
        cnt_r    <= 3'd0;
      end else begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      band_r  <= in_band_index;
      slice_r <= in_slice_index;
      cyl_r   <= (WC'(in_band_index) == stacks_eff);
      upper_r <= (WC'(in_band_index) < (stacks_eff >> 1));
    end
  end

  // ------------------------------------------- stage 1: angles and offset
  // vertex order P1 P2 P3 P2 P4 P3: second latitude on 2,4,5; second slice on 1,3,4
  logic        phi_sel, theta_sel;
  logic [24:0] phi_prod, theta_prod;

  assign phi_sel    = (cnt_r == 3'd2) || (cnt_r == 3'd4) || (cnt_r == 3'd5);
  assign theta_sel  = (cnt_r == 3'd1) || (cnt_r == 3'd3) || (cnt_r == 3'd4);
  assign phi_prod   = 25'((10'(band_r) + 10'(phi_sel)) * 25'(phi_step_r));
  assign theta_prod = 25'((9'(slice_r) + 9'(theta_sel)) * 25'(theta_step_r));

  logic               s1_v_r, s1_last_r;
  logic [15:0]        s1_phi_r, s1_theta_r;
  logic signed [16:0] s1_off_r;
  logic               off_neg;

  // cylinder: upper ring for points A and B, lower ring for C and D
  assign off_neg = cyl_r ? phi_sel : !upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= active_r;
  end

  always_ff @(posedge clk) begin
    s1_last_r  <= (cnt_r == capv_pkg::LAST_VTX);
    s1_phi_r   <= cyl_r ? capv_pkg::QUARTER_TURN : phi_prod[15:0];
    s1_theta_r <= theta_prod[15:0];
    s1_off_r   <= off_neg ? -$signed({1'b0, half_height_r}) : $signed({1'b0, half_height_r});
  end

  // -------------------------------------------------- stage 2: sine lookup
  logic signed [15:0] sp, cp, st, ct;

  capv_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin_phi (
    .angle(s1_phi_r), .sine(sp));
  capv_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_phi (
    .angle(s1_phi_r + capv_pkg::QUARTER_TURN), .sine(cp));
  capv_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin_theta (
    .angle(s1_theta_r), .sine(st));
  capv_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cos_theta (
    .angle(s1_theta_r + capv_pkg::QUARTER_TURN), .sine(ct));

  logic               s2_v_r, s2_last_r;
  logic signed [15:0] s2_sp_r, s2_cp_r, s2_st_r, s2_ct_r;
  logic signed [16:0] s2_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_last_r <= s1_last_r;
    s2_sp_r   <= sp;
    s2_cp_r   <= cp;
    s2_st_r   <= st;
    s2_ct_r   <= ct;
    s2_off_r  <= s1_off_r;
  end

  // ------------------------------------------- stage 3: first q14 products
  logic signed [31:0] radius_s;
  logic signed [31:0] rs, rc, nx, nz;

  assign radius_s = 32'(signed'({1'b0, radius_r}));
  assign rs = capv_pkg::mul14(radius_s, 32'(s2_sp_r));
  assign rc = capv_pkg::mul14(radius_s, 32'(s2_cp_r));
  assign nx = capv_pkg::mul14(32'(s2_sp_r), 32'(s2_ct_r));
  assign nz = capv_pkg::mul14(32'(s2_sp_r), 32'(s2_st_r));

  logic               s3_v_r, s3_last_r;
  logic signed [17:0] s3_rs_r, s3_rc_r;
  logic signed [15:0] s3_nx_r, s3_ny_r, s3_nz_r, s3_st_r, s3_ct_r;
  logic signed [16:0] s3_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    s3_last_r <= s2_last_r;
    s3_rs_r   <= rs[17:0];
    s3_rc_r   <= rc[17:0];
    s3_nx_r   <= nx[15:0];
    s3_ny_r   <= s2_cp_r;
    s3_nz_r   <= nz[15:0];
    s3_st_r   <= s2_st_r;
    s3_ct_r   <= s2_ct_r;
    s3_off_r  <= s2_off_r;
  end

  // ------------------------------------- stage 4: positions and output regs
  logic signed [31:0] px, pz;

  assign px = capv_pkg::mul14(32'(s3_rs_r), 32'(s3_ct_r));
  assign pz = capv_pkg::mul14(32'(s3_rs_r), 32'(s3_st_r));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    out_pos_x       <= px[23:0];
    out_pos_y       <= 24'(s3_rc_r) + 24'(s3_off_r);
    out_pos_z       <= pz[23:0];
    out_norm_x      <= s3_nx_r;
    out_norm_y      <= s3_ny_r;
    out_norm_z      <= s3_nz_r;
    out_last_vertex <= s3_last_r;
  end

  // --------------------------------------------------------------- checks
  a_busy_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> active_r)
    else $error("busy without an active cell");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r <= capv_pkg::LAST_VTX))
    else $error("vertex counter past the sixth vertex");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && (cnt_r == capv_pkg::LAST_VTX)) |=> (cnt_r == 3'd0))
    else $error("counter did not wrap after the sixth vertex");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_last_r) |=> (out_valid && out_last_vertex))
    else $error("last vertex lost in the output stage");

endmodule
